@@ rtl/spdf_pkg.sv @@
// shared constants, types and crc function for the serial packet deframer
package spdf_pkg;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'h0000;
    localparam logic [8:0]  HDR_BYTES = 9'd3;
    localparam logic [8:0]  POS_ADDR  = 9'd0;
    localparam logic [8:0]  POS_FUNC  = 9'd1;

    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_FRAME_END = 1'b1
    } t_item_kind;

    typedef struct packed {
        logic update;
        logic clear;
    } t_crc_ctrl;

    // one byte of crc-16/xmodem, msb first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/spdf_crc16.sv @@
// running crc-16/xmodem register with byte-wide update
module spdf_crc16
    import spdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_crc_ctrl   i_ctrl,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctrl.clear) begin
            n_crc = CRC_INIT;
        end else if (i_ctrl.update) begin
            n_crc = crc16_update(r_crc, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

@@ rtl/serial_packet_deframer_crc16.sv @@
// Serial packet deframer: splits a byte stream into frames of a 3-byte header (address,
// function code, payload length), the payload and a crc-16/xmodem sent low byte first.
// Each payload byte goes out as one request tagged payload; the second crc byte yields
// one frame-end request with the header fields and the crc check result. Header bytes
// and the low crc byte produce nothing. A byte passes an input register, the framing and
// crc logic, and lands in the output register; one byte per cycle is sustained while the
// output is not stalled, with a byte-wide crc update. A bad crc is reported and framing
// simply restarts at the next byte.
module serial_packet_deframer_crc16
    import spdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_item_kind,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_device_addr,
    output logic [7:0] o_function_code,
    output logic [7:0] o_payload_length,
    output logic       o_crc_match
);

    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic [8:0]  r_pos;
    logic [8:0]  n_pos;
    logic [7:0]  r_hdr_addr;
    logic [7:0]  r_hdr_func;
    logic [7:0]  r_hdr_len;
    logic [7:0]  r_crc_lo;
    logic        r_out_valid;
    t_item_kind  r_out_kind;
    logic [7:0]  r_out_byte;
    logic [7:0]  r_out_addr;
    logic [7:0]  r_out_func;
    logic [7:0]  r_out_len;
    logic        r_out_match;

    logic        out_free;
    logic        s1_fire;
    logic        in_fire;
    logic [8:0]  pay_end;
    logic        is_hdr;
    logic        is_pay;
    logic        is_crc_lo;
    logic        is_crc_hi;
    logic [15:0] crc;
    t_crc_ctrl   crc_ctrl;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    assign pay_end   = HDR_BYTES + {1'b0, r_hdr_len};
    assign is_hdr    = r_pos < HDR_BYTES;
    assign is_pay    = !is_hdr && (r_pos < pay_end);
    assign is_crc_lo = !is_hdr && (r_pos == pay_end);
    assign is_crc_hi = !is_hdr && (r_pos > pay_end);

    assign crc_ctrl.update = s1_fire && (is_hdr || is_pay);
    assign crc_ctrl.clear  = s1_fire && is_crc_hi;

    spdf_crc16 u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .i_byte  (r_s1_byte),
        .o_crc   (crc)
    );

    always_comb begin
        n_pos = r_pos;
        if (s1_fire) begin
            n_pos = is_crc_hi ? 9'd0 : r_pos + 9'd1;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte <= i_rx_byte;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 9'd0;
            r_hdr_addr <= 8'd0;
            r_hdr_func <= 8'd0;
            r_hdr_len  <= 8'd0;
            r_crc_lo   <= 8'd0;
        end else begin
            r_pos <= n_pos;
            if (s1_fire && is_hdr) begin
                if (r_pos == POS_ADDR) begin
                    r_hdr_addr <= r_s1_byte;
                end else if (r_pos == POS_FUNC) begin
                    r_hdr_func <= r_s1_byte;
                end else begin
                    r_hdr_len <= r_s1_byte;
                end
            end
            if (s1_fire && is_crc_lo) begin
                r_crc_lo <= r_s1_byte;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && (is_pay || is_crc_hi)) begin
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && (is_pay || is_crc_hi)) begin
            r_out_kind  <= is_pay ? KIND_PAYLOAD : KIND_FRAME_END;
            r_out_byte  <= is_pay ? r_s1_byte : 8'd0;
            r_out_addr  <= r_hdr_addr;
            r_out_func  <= r_hdr_func;
            r_out_len   <= r_hdr_len;
            r_out_match <= is_crc_hi && ({r_s1_byte, r_crc_lo} == crc);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_item_kind      = r_out_kind;
    assign o_payload_byte   = r_out_byte;
    assign o_device_addr    = r_out_addr;
    assign o_function_code  = r_out_func;
    assign o_payload_length = r_out_len;
    assign o_crc_match      = r_out_match;

`ifndef SYNTHESIS
    // position never runs past the high crc byte of a full-length frame
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= HDR_BYTES + 9'd256)
        else $error("frame position out of range");

    // the high crc byte closes the frame
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && is_crc_hi |=> r_pos == 9'd0 && crc == CRC_INIT)
        else $error("frame did not restart after crc");

    // a payload request never claims a crc match
    a_pay_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == KIND_PAYLOAD |-> !r_out_match)
        else $error("payload request with crc match set");

    // a frame-end request carries a zero payload byte
    a_end_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == KIND_FRAME_END |-> r_out_byte == 8'd0)
        else $error("frame-end request with nonzero payload byte");

    // a held output request is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_byte)
            && $stable(r_out_kind))
        else $error("stalled output request changed");
`endif

endmodule
